>>> design/twa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_pkg
// Shared constants and types of the trailing window average block.
// ----------------------------------------------------------------------------
package twa_pkg;

   localparam int CHANNELS_DEFAULT   = 32;
   localparam int MAX_WINDOW_DEFAULT = 16;

   localparam int CHANNEL_W = 5;
   localparam int SAMPLE_W  = 24;
   localparam int QUOT_W    = 24;
   localparam int STEP_W    = $clog2(QUOT_W);
   localparam int WLEN_W    = 5;
   localparam int PASS_W    = 6;
   localparam int TDATA_W   = 32;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [WLEN_W-1:0] WINDOW_RESET      = WLEN_W'(8);
   localparam logic [PASS_W-1:0] PASSTHROUGH_RESET = PASS_W'(3);

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LEN  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_PASSTHROUGH = CSR_INDEX_W'(1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPD,
      ST_DIV,
      ST_DONE
   } twa_state_type;

endpackage

>>> design/twa_chan_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_chan_mem
// Per-channel running state memory with valid bits; an entry that is not
// valid reads as zero.
// ----------------------------------------------------------------------------
module twa_chan_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 38
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          clear_all,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] data_ff;
   logic          hit_ff;
   logic          valid_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

>>> design/twa_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_ring_mem
// Sample history RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module twa_ring_mem #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 24
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

>>> design/twa_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twa_divider
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees that the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module twa_divider #(
   parameter int CNTW = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CNTW+twa_pkg::QUOT_W-1:0] dividend,
   input  logic [CNTW-1:0]               divisor,
   output logic                          done,
   output logic [twa_pkg::QUOT_W-1:0]    quotient
);

   localparam int QW = twa_pkg::QUOT_W;

   logic [CNTW-1:0]           rem_ff,  rem_in;
   logic [QW-1:0]             quot_ff, quot_in;
   logic [CNTW-1:0]           dsr_ff;
   logic [twa_pkg::STEP_W-1:0] count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNTW:0]             rem_sh;
   logic                      ge;

   always_comb begin
      rem_sh   = {rem_ff, quot_ff[QW-1]};
      ge       = rem_sh >= {1'b0, dsr_ff};
      rem_in   = ge ? CNTW'(rem_sh - {1'b0, dsr_ff}) : rem_sh[CNTW-1:0];
      quot_in  = {quot_ff[QW-2:0], ge};
      count_in = count_ff - 1'b1;
      busy_in  = busy_ff && (count_ff != '0);
      done_in  = busy_ff && (count_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dividend[CNTW+QW-1:QW];
         quot_ff <= dividend[QW-1:0];
         dsr_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
         count_ff <= twa_pkg::STEP_W'(QW - 1);
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         if (busy_ff) begin
            count_ff <= count_in;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

>>> design/trailing_window_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trailing_window_average
// Per-channel trailing moving average of Q15.8 samples, with passthrough of
// low channels.
// ----------------------------------------------------------------------------
//
//  channel | dir | word contents (lowest bits first)
//  --------+-----+---------------------------------------------------------
//  req_    | in  | tdata: channel[4:0], sample[28:5]; tuser: first_row
//  rsp_    | out | tdata: channel_out[4:0], average[28:5]
//  csr_    | in  | index 0 window_len, index 1 passthrough_channels
//
// One word is in flight at a time. An accepted word takes a state memory
// read, a history read that also starts the bit-serial divider, the write
// back of state and history, the rest of the divide, one quotient bit at a
// time, and the load of the output register. The divider sets the rate.
// Reset is synchronous and active high; it clears the per-channel state
// through valid bits, so no clearing pass is needed.
// A finished word waits in the output register while the next word is taken
// in; a stalled output only holds the block before its result is loaded.
//
module trailing_window_average #(
   parameter int CHANNELS   = twa_pkg::CHANNELS_DEFAULT,
   parameter int MAX_WINDOW = twa_pkg::MAX_WINDOW_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input words: channel [4:0], sample [28:5], zero fill above.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [twa_pkg::TDATA_W-1:0]     req_tdata,
   // Input flag: first_row [0].
   input  logic                            req_tuser,
   // Result words: channel_out [4:0], average [28:5], zero fill above.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [twa_pkg::TDATA_W-1:0]     rsp_tdata,
   // Configuration writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [twa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [twa_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int SAMW = twa_pkg::SAMPLE_W;
   localparam int CHW  = twa_pkg::CHANNEL_W;
   localparam int QW   = twa_pkg::QUOT_W;
   localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNTW = $clog2(MAX_WINDOW + 1);
   localparam int SUMW = SAMW + CNTW;
   localparam int HDEP = CHANNELS * MAX_WINDOW;
   localparam int HAW  = (HDEP > 1) ? $clog2(HDEP) : 1;
   localparam int STW  = SUMW + CNTW + SW;
   localparam int CHAN_CODES = 1 << CHW;

   // Map of the channel field onto a state index (channel modulo CHANNELS).
   logic [CW-1:0] chan_map [CHAN_CODES];
   for (genvar g = 0; g < CHAN_CODES; g++) begin : g_chan_map
      assign chan_map[g] = CW'(g % CHANNELS);
   end

   // Configuration registers.
   logic [twa_pkg::WLEN_W-1:0] wlen_ff;
   logic [twa_pkg::PASS_W-1:0] pass_ff;
   logic                       clear_all;
   logic                       csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign clear_all = csr_fire && (csr_index == twa_pkg::REG_WINDOW_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= twa_pkg::WINDOW_RESET;
         pass_ff <= twa_pkg::PASSTHROUGH_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            twa_pkg::REG_WINDOW_LEN:  wlen_ff <= csr_wdata[twa_pkg::WLEN_W-1:0];
            twa_pkg::REG_PASSTHROUGH: pass_ff <= csr_wdata[twa_pkg::PASS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective window: zero acts as one, anything above the ring as the ring.
   logic [CNTW-1:0] eff_win;
   always_comb begin
      if (wlen_ff == '0) begin
         eff_win = CNTW'(1);
      end else if (32'(wlen_ff) > 32'(MAX_WINDOW)) begin
         eff_win = CNTW'(MAX_WINDOW);
      end else begin
         eff_win = CNTW'(wlen_ff);
      end
   end

   // Word registers and control.
   twa_pkg::twa_state_type state_ff, state_in;
   logic [CHW-1:0]         chan_ff;
   logic [CW-1:0]          cidx_ff;
   logic signed [SAMW-1:0] sample_ff;
   logic                   first_ff;
   logic signed [SUMW-1:0] sum_ff;
   logic [CNTW-1:0]        cnt_ff;
   logic [SW-1:0]          slot_ff;
   logic                   rsp_tvalid_ff;
   logic [twa_pkg::TDATA_W-1:0] rsp_tdata_ff;

   logic req_fire;
   logic load_rsp;
   logic capture;

   // Memory and divider connections.
   logic [STW-1:0]         st_rd_data;
   logic [STW-1:0]         st_wr_data;
   logic signed [SUMW-1:0] st_sum;
   logic [CNTW-1:0]        st_cnt;
   logic [SW-1:0]          st_slot;
   logic [SW-1:0]          slot_eff;
   logic [SUMW-1:0]        st_mag;
   logic [HAW-1:0]         hist_addr_rd;
   logic [HAW-1:0]         hist_addr_wr;
   logic [SAMW-1:0]        hist_rd_data;
   logic                   div_done;
   logic [QW-1:0]          div_quot;

   logic                   full;
   logic signed [SUMW-1:0] new_sum;
   logic [CNTW-1:0]        new_cnt;
   logic [CNTW-1:0]        slot_inc;
   logic [SW-1:0]          new_slot;
   logic                   pass;
   logic [SAMW-1:0]        result;

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      load_rsp   = 1'b0;
      capture    = 1'b0;
      case (state_ff)
         twa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = twa_pkg::ST_READ;
            end
         end
         twa_pkg::ST_READ: begin
            capture  = 1'b1;
            state_in = twa_pkg::ST_UPD;
         end
         twa_pkg::ST_UPD: begin
            state_in = twa_pkg::ST_DIV;
         end
         twa_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = twa_pkg::ST_DONE;
            end
         end
         twa_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = twa_pkg::ST_IDLE;
            end
         end
         default: state_in = twa_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         chan_ff   <= req_tdata[CHW-1:0];
         cidx_ff   <= chan_map[req_tdata[CHW-1:0]];
         sample_ff <= req_tdata[CHW+SAMW-1:CHW];
         first_ff  <= req_tuser;
      end
      if (capture) begin
         sum_ff  <= st_sum;
         cnt_ff  <= st_cnt;
         slot_ff <= slot_eff;
      end
   end

   // Stored state of the channel; a first_row word starts from an empty ring.
   always_comb begin
      {st_sum, st_cnt, st_slot} = first_ff ? '0 : st_rd_data;
      slot_eff     = (CNTW'(st_slot) >= eff_win) ? '0 : st_slot;
      st_mag       = st_sum[SUMW-1] ? SUMW'(-st_sum) : SUMW'(st_sum);
      hist_addr_rd = HAW'(cidx_ff) * HAW'(MAX_WINDOW) + HAW'(slot_eff);
      hist_addr_wr = HAW'(cidx_ff) * HAW'(MAX_WINDOW) + HAW'(slot_ff);
   end

   // Ring update: drop the oldest sample once the window is full.
   always_comb begin
      full     = cnt_ff >= eff_win;
      new_sum  = sum_ff - (full ? SUMW'($signed(hist_rd_data)) : SUMW'(0))
                 + SUMW'(sample_ff);
      new_cnt  = full ? cnt_ff : cnt_ff + 1'b1;
      slot_inc = CNTW'(slot_ff) + 1'b1;
      new_slot = (slot_inc >= eff_win) ? '0 : slot_inc[SW-1:0];
      st_wr_data = {new_sum, new_cnt, new_slot};
   end

   twa_chan_mem #(
      .DEPTH (CHANNELS),
      .AW    (CW),
      .DW    (STW)
   ) u_chan_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .rd_en     (req_fire),
      .rd_addr   (chan_map[req_tdata[CHW-1:0]]),
      .rd_data   (st_rd_data),
      .wr_en     (state_ff == twa_pkg::ST_UPD),
      .wr_addr   (cidx_ff),
      .wr_data   (st_wr_data)
   );

   twa_ring_mem #(
      .DEPTH (HDEP),
      .AW    (HAW),
      .DW    (SAMW)
   ) u_ring_mem (
      .clock   (clock),
      .rd_en   (capture),
      .rd_addr (hist_addr_rd),
      .rd_data (hist_rd_data),
      .wr_en   (state_ff == twa_pkg::ST_UPD),
      .wr_addr (hist_addr_wr),
      .wr_data (sample_ff)
   );

   // The divider works on the magnitude; the sign is put back afterwards so
   // that the mean truncates toward zero.
   twa_divider #(
      .CNTW (CNTW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (capture),
      .dividend (st_mag),
      .divisor  (st_cnt),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      pass = {1'b0, chan_ff} < pass_ff;
      if (pass) begin
         result = sample_ff;
      end else if (cnt_ff == '0) begin
         result = '0;
      end else if (sum_ff[SUMW-1]) begin
         result = SAMW'(-div_quot);
      end else begin
         result = SAMW'(div_quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_tdata_ff <= twa_pkg::TDATA_W'({result, chan_ff});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The divider finishes only while the controller waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == twa_pkg::ST_DIV)
      else $error("divider finished outside the divide phase");

   // A stored fill count never exceeds the effective window.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == twa_pkg::ST_UPD |-> cnt_ff <= eff_win)
      else $error("fill count above the window length");

   // The quotient magnitude stays within the sample range.
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (div_done && cnt_ff != '0) |-> div_quot <= QW'(24'h800000))
      else $error("mean magnitude out of the sample range");

   // A result waiting in the output register is never overwritten.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == twa_pkg::ST_DONE && rsp_tvalid_ff && !rsp_tready)
      |=> state_ff == twa_pkg::ST_DONE)
      else $error("result register overwritten while stalled");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for trailing_window_average. Streams Q15.8 samples
// into the block under random idle gaps and output stalls, predicts every
// average with a model of its own and compares the result words in order.
// ----------------------------------------------------------------------------
module tb;
   import twa_pkg::*;

   localparam int CHANNELS   = CHANNELS_DEFAULT;
   localparam int MAX_WINDOW = MAX_WINDOW_DEFAULT;
   localparam int SUM_W      = 28;
   // Cycles with no handshake on any channel before the run is declared hung.
   // The slowest legal gap between two handshakes is a long sender gap, the
   // block's own processing and a long output stall, well below this.
   localparam int STALL_LIMIT = 2000;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   localparam int SENDER   = 0;
   localparam int RECEIVER = 1;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic [SAMPLE_W-1:0]  average;
   } mean_result_type;

   // Predicts the block: per-channel ring of the last samples, its running
   // sum and fill count, and the two registers. Expected results wait in
   // arrival order until the block hands them out.
   class trailing_mean_model;
      logic [WLEN_W-1:0]          window_len;
      logic [PASS_W-1:0]          passthrough;
      logic signed [SAMPLE_W-1:0] history [CHANNELS][MAX_WINDOW];
      logic signed [SUM_W-1:0]    window_sum [CHANNELS];
      logic [4:0]                 fill_count [CHANNELS];
      logic [4:0]                 write_slot [CHANNELS];
      mean_result_type            awaited [$];
      int                         mismatches;

      function new();
         window_len  = WINDOW_RESET;
         passthrough = PASSTHROUGH_RESET;
         mismatches  = 0;
         foreach (history[c, s]) history[c][s] = '0;
         foreach (window_sum[c]) clear_channel(c);
      endfunction

      function void clear_channel(int c);
         window_sum[c] = '0;
         fill_count[c] = '0;
         write_slot[c] = '0;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == REG_WINDOW_LEN) begin
            // Any window change restarts every channel.
            window_len = value[WLEN_W-1:0];
            foreach (window_sum[c]) clear_channel(c);
         end else if (idx == REG_PASSTHROUGH) begin
            passthrough = value[PASS_W-1:0];
         end
      endfunction

      function void note_sample(logic [CHANNEL_W-1:0] chan, logic signed [SAMPLE_W-1:0] smp,
                                logic first);
         int                      c;
         logic [4:0]              span;
         logic [4:0]              slot;
         logic signed [SUM_W-1:0] divisor;
         logic signed [SUM_W-1:0] mean;
         mean_result_type         res;
         c = int'(chan) % CHANNELS;
         // A zero window behaves as one, anything past the ring size as the ring size.
         if (window_len == 0) span = 5'd1;
         else if (window_len > MAX_WINDOW) span = 5'(MAX_WINDOW);
         else span = window_len;
         if (first) clear_channel(c);
         // The mean covers earlier samples only; signed division truncates toward zero.
         mean = '0;
         if (fill_count[c] != 0) begin
            divisor = SUM_W'(fill_count[c]);
            mean = window_sum[c] / divisor;
         end
         res.channel = chan;
         res.average = ({1'b0, chan} < passthrough) ? smp : mean[SAMPLE_W-1:0];
         // Push the current sample, dropping the oldest once the ring is full.
         slot = write_slot[c];
         if (slot >= span) slot = '0;
         if (fill_count[c] >= span) window_sum[c] -= history[c][slot];
         else fill_count[c] += 1;
         history[c][slot] = smp;
         window_sum[c] += smp;
         slot += 1;
         if (slot >= span) slot = '0;
         write_slot[c] = slot;
         awaited.push_back(res);
      endfunction

      function void check_result(logic [TDATA_W-1:0] word);
         mean_result_type      want;
         logic [CHANNEL_W-1:0] got_chan;
         logic [SAMPLE_W-1:0]  got_avg;
         got_chan = word[CHANNEL_W-1:0];
         got_avg  = word[CHANNEL_W+SAMPLE_W-1:CHANNEL_W];
         if (awaited.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, got %h", $time, word);
            return;
         end
         want = awaited.pop_front();
         if (got_chan !== want.channel) begin
            mismatches++;
            $display("%0t: channel_out expected %0d, got %0d", $time, want.channel,
                     got_chan);
         end
         if (got_avg !== want.average) begin
            mismatches++;
            $display("%0t: average on channel %0d expected %0d, got %0d", $time,
                     want.channel, $signed(want.average), $signed(got_avg));
         end
         if (word[TDATA_W-1:CHANNEL_W+SAMPLE_W] !== '0) begin
            mismatches++;
            $display("%0t: fill bits expected 0, got %h", $time,
                     word[TDATA_W-1:CHANNEL_W+SAMPLE_W]);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [TDATA_W-1:0]     req_tdata;   // channel [4:0], sample [28:5], zero fill above
   logic                   req_tuser;   // first_row [0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [TDATA_W-1:0]     rsp_tdata;   // channel_out [4:0], average [28:5], zero fill above
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   trailing_mean_model averager;
   // Remaining words of a stretch without idling, one count per side.
   int calm_left [2];
   int quiet_cycles;

   trailing_window_average u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle length in cycles for one side. Most gaps are zero or short, a few
   // are long, and now and then a stretch of words goes by with no gap at all.
   function automatic int idle_length(int side);
      int pick;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 50) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offers one sample word after a random gap. The valid stays high after
   // the handshake so that back-to-back words need only one assignment per edge.
   task automatic send_sample(input logic [CHANNEL_W-1:0] chan,
                              input logic signed [SAMPLE_W-1:0] smp, input logic first);
      int gap;
      gap = idle_length(SENDER);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         // Junk on the bus while idle must be ignored by the block.
         req_tdata  <= $urandom;
         req_tuser  <= 1'($urandom);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_W'({smp, chan});
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      averager.note_sample(chan, smp, first);
   endtask

   // Stops offering words and waits for every predicted average to come back,
   // so that the block is idle before registers change.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (averager.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      averager.write_reg(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Fills one channel with a run of a single extreme value, longer than the
   // largest window, so the running sum reaches its limits and the ring wraps.
   task automatic extreme_run();
      logic [CHANNEL_W-1:0]       chan;
      logic signed [SAMPLE_W-1:0] level;
      chan  = CHANNEL_W'($urandom_range(24, 31));
      level = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
      send_sample(chan, level, 1'b1);
      repeat (MAX_WINDOW + 1) send_sample(chan, level, 1'b0);
   endtask

   // Random words. Most go to a few busy channels so that windows fill and
   // wrap; the rest spread over all channels. The first-row flag is rare so
   // histories grow long between restarts.
   task automatic random_samples(input int count);
      logic [CHANNEL_W-1:0]       busy [4];
      logic [CHANNEL_W-1:0]       chan;
      logic signed [SAMPLE_W-1:0] smp;
      int                         pick;
      foreach (busy[i]) busy[i] = CHANNEL_W'($urandom);
      repeat (count) begin
         chan = ($urandom_range(0, 9) < 6) ? busy[$urandom_range(0, 3)]
                                           : CHANNEL_W'($urandom);
         pick = $urandom_range(0, 15);
         if (pick == 0) smp = SAMPLE_MIN;
         else if (pick == 1) smp = SAMPLE_MAX;
         // Small values make truncation toward zero visible on both signs.
         else if (pick < 6) smp = SAMPLE_W'($urandom_range(0, 1023) - 512);
         else smp = SAMPLE_W'($urandom);
         send_sample(chan, smp, $urandom_range(0, 29) == 0);
      end
   endtask

   // Output side: ready toggles with random stalls, each level held for a random stretch.
   initial begin
      int hold_cycles;
      int stall;
      hold_cycles = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            hold_cycles--;
         end else begin
            stall = idle_length(RECEIVER);
            rsp_tready <= (stall == 0);
            hold_cycles = (stall == 0) ? $urandom_range(0, 6) : stall - 1;
         end
      end
   end

   // Every accepted result word is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) averager.check_result(rsp_tdata);
   end

   // Watchdog: a run that stops moving words on every channel is hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      averager     = new();
      calm_left[SENDER]   = 0;
      calm_left[RECEIVER] = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: window of 8, channels 0 to 2
      // passed through.
      // Passthrough copies the extremes unchanged, with or without a restart.
      send_sample(5'd0, SAMPLE_MAX, 1'b0);
      send_sample(5'd2, SAMPLE_MIN, 1'b1);
      // First sample of a channel averages to zero; then a mean of 5 and
      // -8 gives -1, truncated toward zero rather than down.
      send_sample(5'd3, 24'sd5, 1'b0);
      send_sample(5'd3, -24'sd8, 1'b0);
      send_sample(5'd3, 24'sd0, 1'b0);
      // A full window of the largest sample wraps the ring; a restart then
      // gives zero again.
      send_sample(5'd31, SAMPLE_MAX, 1'b1);
      repeat (8) send_sample(5'd31, SAMPLE_MAX, 1'b0);
      send_sample(5'd31, SAMPLE_MAX, 1'b1);
      // The same with the smallest sample, followed by a jump to the largest.
      send_sample(5'd30, SAMPLE_MIN, 1'b1);
      repeat (8) send_sample(5'd30, SAMPLE_MIN, 1'b0);
      send_sample(5'd30, SAMPLE_MAX, 1'b0);
      extreme_run();
      random_samples(85);

      // Each later phase changes the registers while the block is idle. Some raw
      // write values carry set upper bits that the registers must drop.
      for (int phase = 1; phase <= 9; phase++) begin
         settle();
         case (phase)
            1: begin
               csr_write(REG_WINDOW_LEN, 8'h01);
               csr_write(REG_PASSTHROUGH, 8'h00);
            end
            2: begin
               csr_write(REG_WINDOW_LEN, 8'h10);
               csr_write(REG_PASSTHROUGH, 8'h20);
            end
            3: begin
               // Window zero behaves as one; 63 passes every channel through.
               csr_write(REG_WINDOW_LEN, 8'hE0);
               csr_write(REG_PASSTHROUGH, 8'h3F);
            end
            4: begin
               // Window 31 is clamped to the ring size.
               csr_write(REG_WINDOW_LEN, 8'hFF);
               csr_write(REG_PASSTHROUGH, 8'hC5);
            end
            5: begin
               csr_write(REG_WINDOW_LEN, 8'h11);
               csr_write(REG_PASSTHROUGH, 8'h10);
               // Writes to unused indexes must change nothing.
               for (int idx = REG_PASSTHROUGH + 1; idx < 2 ** CSR_INDEX_W; idx++)
                  csr_write(CSR_INDEX_W'(idx), CSR_DATA_W'($urandom));
            end
            6: begin
               // Passthrough alone changes; histories must survive it.
               csr_write(REG_PASSTHROUGH, 8'h02);
            end
            7: begin
               csr_write(REG_WINDOW_LEN, 8'h05);
               csr_write(REG_PASSTHROUGH, 8'h01);
            end
            default: begin
               csr_write(REG_WINDOW_LEN, CSR_DATA_W'($urandom));
               csr_write(REG_PASSTHROUGH, CSR_DATA_W'($urandom));
            end
         endcase
         extreme_run();
         random_samples(85);
      end

      settle();
      // Let any stray word show up before the verdict.
      repeat (40) @(posedge clock);
      if (averager.mismatches == 0 && averager.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
